// File: design/jsr_pkg.sv
// shared types and constants of the joystick servo ramp block
`timescale 1ns / 1ps

package jsr_pkg;

    localparam int NUM_JOINTS = 4;
    localparam int JOINT_W    = 2;
    localparam int ANGLE_W    = 8;
    localparam int PULSE_W    = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic CMD_JOY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [ANGLE_W-1:0] STICK_HIGH = 8'd200;
    localparam logic [ANGLE_W-1:0] STICK_LOW  = 8'd50;
    localparam logic [ANGLE_W:0]   STEP_DEG   = 9'd3;
    localparam logic [ANGLE_W:0]   WRAP_BIG   = 9'h1FF;
    localparam logic [ANGLE_W-1:0] HOME_ANGLE = 8'd90;
    localparam logic [PULSE_W-1:0] PULSE_BASE = 12'd500;

    // floor(pos*100/9) == (pos * 100 * ceil(2^18/9)) >> 18 for pos*100 < 2^15
    localparam int PULSE_SHIFT = 18;
    localparam int PROD_W      = 30;
    localparam logic [21:0] PULSE_MULT = 22'd2912800;

    localparam logic [JOINT_W-1:0] LAST_JOINT = 2'd3;

    localparam logic [ANGLE_W-1:0] MIN_RESET [NUM_JOINTS] = '{8'd25, 8'd35, 8'd45, 8'd20};
    localparam logic [ANGLE_W-1:0] MAX_RESET [NUM_JOINTS] = '{8'd100, 8'd120, 8'd160, 8'd160};

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_JOY  = 6'b000010,
        ST_SEEK = 6'b000100,
        ST_STEP = 6'b001000,
        ST_CALC = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    typedef struct packed {
        logic load_targets;
        logic seek_step;
        logic step;
        logic calc;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pending;
        logic seek_end;
        logic reached;
        logic active_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/jsr_in_if.sv
// input channel: joystick samples and ramp ticks
`timescale 1ns / 1ps

interface jsr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] stick_lx;
    logic [7:0] stick_ly;
    logic [7:0] stick_rx;
    logic [7:0] stick_ry;

    modport source (output valid, output cmd, output stick_lx, output stick_ly,
                    output stick_rx, output stick_ry, input ready);
    modport sink (input valid, input cmd, input stick_lx, input stick_ly,
                  input stick_rx, input stick_ry, output ready);
endinterface

// File: design/jsr_out_if.sv
// output channel: servo pulse widths
`timescale 1ns / 1ps

interface jsr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  joint_index;
    logic [11:0] pulse_width;
    logic        ramp_done;

    modport source (output valid, output joint_index, output pulse_width,
                    output ramp_done, input ready);
    modport sink (input valid, input joint_index, input pulse_width,
                  input ramp_done, output ready);
endinterface

// File: design/jsr_ctrl.sv
// control state machine of the servo ramp block
`timescale 1ns / 1ps

module jsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    input  jsr_pkg::dp_stat_t stat,
    output jsr_pkg::ctrl_cmd_t cmd
);

    jsr_pkg::state_t state_reg, state_next;
    logic            tick_reg, tick_next;
    logic            in_fire;

    assign in_ready = (state_reg == jsr_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        cmd        = '0;
        unique case (state_reg)
            jsr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == jsr_pkg::CMD_JOY && !stat.pending)
                    begin
                        state_next = jsr_pkg::ST_JOY;
                        tick_next  = 1'b0;
                    end
                    else if (in_cmd == jsr_pkg::CMD_TICK && stat.pending)
                    begin
                        state_next = jsr_pkg::ST_STEP;
                        tick_next  = 1'b1;
                    end
                end
            end
            jsr_pkg::ST_JOY:
            begin
                cmd.load_targets = 1'b1;
                state_next       = jsr_pkg::ST_SEEK;
            end
            jsr_pkg::ST_SEEK:
            begin
                cmd.seek_step = 1'b1;
                if (stat.seek_end)
                    state_next = tick_reg ? jsr_pkg::ST_EMIT : jsr_pkg::ST_IDLE;
            end
            jsr_pkg::ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = jsr_pkg::ST_CALC;
            end
            jsr_pkg::ST_CALC:
            begin
                cmd.calc = 1'b1;
                // a finished joint hands over to the next unfinished one
                if (stat.reached && !stat.active_last)
                    state_next = jsr_pkg::ST_SEEK;
                else
                    state_next = jsr_pkg::ST_EMIT;
            end
            jsr_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = jsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jsr_pkg::ST_IDLE;
            tick_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

// File: design/jsr_dp.sv
// datapath: limits, joint angles, pulse arithmetic and output register
`timescale 1ns / 1ps

module jsr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_fire,
    input  logic [jsr_pkg::ANGLE_W-1:0]   stick_lx,
    input  logic [jsr_pkg::ANGLE_W-1:0]   stick_ly,
    input  logic [jsr_pkg::ANGLE_W-1:0]   stick_rx,
    input  logic [jsr_pkg::ANGLE_W-1:0]   stick_ry,
    input  logic                          cfg_we,
    input  logic [jsr_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [jsr_pkg::ANGLE_W-1:0]   cfg_wdata,
    input  jsr_pkg::ctrl_cmd_t            cmd,
    output jsr_pkg::dp_stat_t             stat,
    jsr_out_if.source                     pulses
);

    localparam int NJ = jsr_pkg::NUM_JOINTS;
    localparam int AW = jsr_pkg::ANGLE_W;
    localparam int JW = jsr_pkg::JOINT_W;
    localparam int PW = jsr_pkg::PULSE_W;

    logic [AW-1:0] min_reg [NJ];
    logic [AW-1:0] max_reg [NJ];
    logic [AW-1:0] stick_reg [NJ];
    logic [AW-1:0] target_reg [NJ];
    logic [AW-1:0] target_next [NJ];
    logic [AW-1:0] committed_reg [NJ];
    logic [AW-1:0] moving_reg, moving_next;
    logic [JW-1:0] active_reg;
    logic [JW-1:0] seek_idx_reg;
    logic          pending_reg;
    logic [jsr_pkg::PROD_W-1:0] prod_reg;
    logic [PW-1:0] pulse_reg;
    logic [JW-1:0] joint_reg;

    logic          out_valid_reg;
    logic [JW-1:0] out_joint_reg;
    logic [PW-1:0] out_pulse_reg;
    logic          out_done_reg;

    logic [JW-1:0] jidx;
    logic [AW-1:0] tgt_sel;
    logic [AW-1:0] com_sel;
    logic          seek_hit;
    logic          reached;

    // one read port onto the joint registers
    assign jidx    = cmd.seek_step ? seek_idx_reg : active_reg;
    assign tgt_sel = target_reg[jidx];
    assign com_sel = committed_reg[jidx];
    assign seek_hit = (com_sel != tgt_sel);
    assign reached  = (moving_reg == tgt_sel);

    assign stat.pending     = pending_reg;
    assign stat.seek_end    = seek_hit || (seek_idx_reg == jsr_pkg::LAST_JOINT);
    assign stat.reached     = reached;
    assign stat.active_last = (active_reg == jsr_pkg::LAST_JOINT);
    assign stat.out_free    = !out_valid_reg || pulses.ready;

    assign pulses.valid       = out_valid_reg;
    assign pulses.joint_index = out_joint_reg;
    assign pulses.pulse_width = out_pulse_reg;
    assign pulses.ramp_done   = out_done_reg;

    // new targets, four lanes in parallel
    always_comb
    begin
        logic [AW:0] up;
        logic [AW:0] down;
        logic [AW:0] t;
        logic        inv;
        for (int k = 0; k < NJ; k++)
        begin
            inv  = (k == 1);
            up   = {1'b0, committed_reg[k]} + jsr_pkg::STEP_DEG;
            // a decrement below zero wraps high and ends clamped to the max
            down = (committed_reg[k] >= jsr_pkg::STEP_DEG[AW-1:0])
                   ? ({1'b0, committed_reg[k]} - jsr_pkg::STEP_DEG)
                   : jsr_pkg::WRAP_BIG;
            t = {1'b0, target_reg[k]};
            if (stick_reg[k] > jsr_pkg::STICK_HIGH)
                t = inv ? down : up;
            if (stick_reg[k] < jsr_pkg::STICK_LOW)
                t = inv ? up : down;
            if (t <= {1'b0, min_reg[k]})
                t = {1'b0, min_reg[k]};
            if (t >= {1'b0, max_reg[k]})
                t = {1'b0, max_reg[k]};
            target_next[k] = t[AW-1:0];
        end
    end

    always_comb
    begin
        moving_next = moving_reg;
        if (moving_reg > tgt_sel)
            moving_next = moving_reg - 1'b1;
        else if (moving_reg < tgt_sel)
            moving_next = moving_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NJ; k++)
            begin
                min_reg[k] <= jsr_pkg::MIN_RESET[k];
                max_reg[k] <= jsr_pkg::MAX_RESET[k];
            end
        end
        else if (cfg_we)
        begin
            if (cfg_idx[JW])
                max_reg[cfg_idx[JW-1:0]] <= cfg_wdata;
            else
                min_reg[cfg_idx[JW-1:0]] <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stick_reg[0] <= stick_lx;
            stick_reg[1] <= stick_ly;
            stick_reg[2] <= stick_rx;
            stick_reg[3] <= stick_ry;
        end
        if (cmd.step)
            prod_reg <= jsr_pkg::PROD_W'(moving_next) * jsr_pkg::PROD_W'(jsr_pkg::PULSE_MULT);
        if (cmd.calc)
        begin
            pulse_reg <= jsr_pkg::PULSE_BASE
                         + PW'(prod_reg[jsr_pkg::PROD_W-1:jsr_pkg::PULSE_SHIFT]);
            joint_reg <= active_reg;
        end
        if (cmd.load_out)
        begin
            out_joint_reg <= joint_reg;
            out_pulse_reg <= pulse_reg;
            out_done_reg  <= !pending_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NJ; k++)
            begin
                target_reg[k]    <= jsr_pkg::HOME_ANGLE;
                committed_reg[k] <= '0;
            end
            moving_reg    <= '0;
            active_reg    <= '0;
            seek_idx_reg  <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_targets)
            begin
                for (int k = 0; k < NJ; k++)
                    target_reg[k] <= target_next[k];
                seek_idx_reg <= '0;
            end
            if (cmd.seek_step)
            begin
                if (seek_hit)
                begin
                    moving_reg  <= com_sel;
                    active_reg  <= seek_idx_reg;
                    pending_reg <= 1'b1;
                end
                else if (seek_idx_reg == jsr_pkg::LAST_JOINT)
                begin
                    active_reg  <= '0;
                    pending_reg <= 1'b0;
                end
                else
                begin
                    seek_idx_reg <= seek_idx_reg + 1'b1;
                end
            end
            if (cmd.step)
                moving_reg <= moving_next;
            if (cmd.calc && reached)
            begin
                committed_reg[active_reg] <= tgt_sel;
                seek_idx_reg <= active_reg + 1'b1;
                if (active_reg == jsr_pkg::LAST_JOINT)
                begin
                    active_reg  <= '0;
                    pending_reg <= 1'b0;
                end
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (pulses.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// File: design/joystick_servo_ramp.sv
// A joystick beat is taken while the block is idle and sets the four joint
// targets in the next cycle, then a seek walks the joints one per cycle,
// up to all four, to find the first one that must move. A tick beat with a
// ramp running goes through accept, step and multiply, pulse and emit,
// plus a seek step for each later joint examined when a joint other than
// the last finishes; beats that are ignored end at their acceptance. The
// pulse goes into an output register, so a finished pulse can wait on the
// sink while the next beat is accepted; a tick stalls in its emit step
// only if the earlier pulse has still not been taken. Limit registers are
// to be written only while the block is idle, which the block itself does
// not enforce; they take effect on the next joystick beat.
`timescale 1ns / 1ps

module joystick_servo_ramp (
    input  logic                          clk,
    input  logic                          rst_n,
    jsr_in_if.sink                        items,
    jsr_out_if.source                     pulses,
    input  logic                          cfg_we,
    input  logic [jsr_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [jsr_pkg::ANGLE_W-1:0]   cfg_wdata
);

    jsr_pkg::ctrl_cmd_t cmd;
    jsr_pkg::dp_stat_t  stat;
    logic               in_ready;

    assign items.ready = in_ready;

    jsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_cmd   (items.cmd),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (items.valid && in_ready),
        .stick_lx  (items.stick_lx),
        .stick_ly  (items.stick_ly),
        .stick_rx  (items.stick_rx),
        .stick_ry  (items.stick_ry),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .pulses    (pulses)
    );

endmodule
